FILE: rtl/gsa_pkg.sv
// Package for the generational slot allocator.
// Holds the operation and status codes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package gsa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned HSLOT_W   = 16;
  localparam int unsigned GEN_W     = 16;
  localparam int unsigned SLOTIDX_W = 10;
  localparam int unsigned ALLOC_W   = 11;
  // Wide enough to compare a handle's slot field with any allocated count.
  localparam int unsigned CMP_W     = HSLOT_W + 1;

  localparam logic [GEN_W-1:0] GEN_MAX = 16'hffff;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_RETIRE  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Controller states.
  typedef enum logic {
    GSA_IDLE,
    GSA_EXEC
  } gsa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the item and launch the memory reads
    logic execute;   // apply the operation and load the result register
  } gsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // result register holds an item that is not taken
  } gsa_sts_t;

endpackage

FILE: rtl/gsa_req_if.sv
// Request channel interface: operation code and packed handle.
// Depends on gsa_pkg for the field widths.
interface gsa_req_if;
  logic                           valid;
  logic                           ready;
  logic [gsa_pkg::OP_W-1:0]       op;
  logic [gsa_pkg::HANDLE_W-1:0]   handle;

  modport source (output valid, output op, output handle, input ready);
  modport sink   (input valid, input op, input handle, output ready);
endinterface

FILE: rtl/gsa_rsp_if.sv
// Response channel interface: status, new handle, slot and allocated count.
// Depends on gsa_pkg for the field widths.
interface gsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [gsa_pkg::STATUS_W-1:0]    status;
  logic [gsa_pkg::HANDLE_W-1:0]    handle_out;
  logic [gsa_pkg::SLOTIDX_W-1:0]   slot_index;
  logic [gsa_pkg::ALLOC_W-1:0]     allocated_slots;

  modport source (output valid, output status, output handle_out,
                  output slot_index, output allocated_slots, input ready);
  modport sink   (input valid, input status, input handle_out,
                  input slot_index, input allocated_slots, output ready);
endinterface

FILE: rtl/gsa_ctrl.sv
// Controller of the generational slot allocator: a two-state machine that
// accepts an item, then lets the datapath execute it. Depends on gsa_pkg.
module gsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsa_pkg::gsa_sts_t sts,
  output gsa_pkg::gsa_cmd_t cmd
);

  gsa_pkg::gsa_state_t state;
  gsa_pkg::gsa_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::GSA_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      gsa_pkg::GSA_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = gsa_pkg::GSA_EXEC;
        end
      end
      gsa_pkg::GSA_EXEC: begin
        // Wait here while the previous result has not been taken.
        if (!sts.out_blocked) begin
          cmd.execute = 1'b1;
          state_next  = gsa_pkg::GSA_IDLE;
        end
      end
      default: begin
        state_next = gsa_pkg::GSA_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/gsa_datapath.sv
// Datapath of the generational slot allocator: generation memory, free
// stack memory, counters and the result register. Depends on gsa_pkg.
module gsa_datapath #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gsa_pkg::gsa_cmd_t               cmd,
  output gsa_pkg::gsa_sts_t               sts,
  input  logic [gsa_pkg::OP_W-1:0]        in_op,
  input  logic [gsa_pkg::HANDLE_W-1:0]    in_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gsa_pkg::STATUS_W-1:0]    out_status,
  output logic [gsa_pkg::HANDLE_W-1:0]    out_handle,
  output logic [gsa_pkg::SLOTIDX_W-1:0]   out_slot,
  output logic [gsa_pkg::ALLOC_W-1:0]     out_alloc
);

  localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

  // Memories.
  logic [gsa_pkg::GEN_W-1:0] gen_mem [MAX_SLOTS];
  logic [SLOT_W-1:0]         stk_mem [MAX_SLOTS];

  // Counters.
  logic [gsa_pkg::GEN_W-1:0] gen_ctr;
  logic [CNT_W-1:0]          free_count;
  logic [CNT_W-1:0]          alloc_count;

  // Captured item and registered read data.
  logic [gsa_pkg::OP_W-1:0]     op_q;
  logic [gsa_pkg::HANDLE_W-1:0] handle_q;
  logic [gsa_pkg::GEN_W-1:0]    gen_rd;
  logic [SLOT_W-1:0]            stk_rd;

  logic [CNT_W-1:0]             free_dec;
  logic [gsa_pkg::HSLOT_W-1:0]  hslot;
  logic [gsa_pkg::GEN_W-1:0]    hgen;
  logic                         live;
  logic [gsa_pkg::GEN_W-1:0]    gen_inc;
  logic                         acq_pop;
  logic                         acq_new;
  logic [SLOT_W-1:0]            acq_slot;
  logic [SLOT_W-1:0]            res_slot;
  logic [gsa_pkg::STATUS_W-1:0] res_status;
  logic [gsa_pkg::HANDLE_W-1:0] res_handle;
  logic                         gen_we;
  logic [SLOT_W-1:0]            gen_wa;
  logic [gsa_pkg::GEN_W-1:0]    gen_wd;
  logic                         stk_we;
  logic                         do_acq;
  logic                         do_pop;
  logic                         do_new;
  logic                         do_push;

  assign free_dec = free_count - CNT_W'(1);

  // Generation memory: read at the handle's slot when the item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gen_rd <= gen_mem[in_handle[SLOT_W-1:0]];
    end
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
  end

  // Free stack memory: the top entry is read when the item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stk_rd <= stk_mem[free_dec[SLOT_W-1:0]];
    end
    if (stk_we) begin
      stk_mem[free_count[SLOT_W-1:0]] <= res_slot;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= in_op;
      handle_q <= in_handle;
    end
  end

  // Handle check and acquire selection.
  assign hslot   = handle_q[gsa_pkg::HSLOT_W-1:0];
  assign hgen    = handle_q[gsa_pkg::HANDLE_W-1 -: gsa_pkg::GEN_W];
  assign live    = (hgen != '0)
                && (gsa_pkg::CMP_W'(hslot) < gsa_pkg::CMP_W'(alloc_count))
                && (gen_rd == hgen);
  assign gen_inc = (gen_ctr == gsa_pkg::GEN_MAX) ? gsa_pkg::GEN_W'(1)
                                                 : gen_ctr + gsa_pkg::GEN_W'(1);
  assign acq_pop  = (free_count != '0);
  assign acq_new  = !acq_pop && (alloc_count < CNT_MAX);
  assign acq_slot = acq_pop ? stk_rd : alloc_count[SLOT_W-1:0];

  // Result and update decisions for the operation.
  always_comb begin
    res_status = gsa_pkg::ST_BAD;
    res_handle = '0;
    res_slot   = '0;
    do_acq     = 1'b0;
    do_pop     = 1'b0;
    do_new     = 1'b0;
    do_push    = 1'b0;
    gen_we     = 1'b0;
    gen_wa     = '0;
    gen_wd     = '0;
    unique case (op_q)
      gsa_pkg::OP_ACQUIRE: begin
        if (acq_pop || acq_new) begin
          res_status = gsa_pkg::ST_OK;
          res_slot   = acq_slot;
          res_handle = {gen_inc, gsa_pkg::HSLOT_W'(acq_slot)};
          do_acq     = 1'b1;
          do_pop     = acq_pop;
          do_new     = acq_new;
          gen_we     = cmd.execute;
          gen_wa     = acq_slot;
          gen_wd     = gen_inc;
        end else begin
          res_status = gsa_pkg::ST_FULL;
        end
      end
      gsa_pkg::OP_LOOKUP: begin
        if (live) begin
          res_status = gsa_pkg::ST_OK;
          res_slot   = hslot[SLOT_W-1:0];
        end
      end
      gsa_pkg::OP_RETIRE: begin
        if (live) begin
          res_status = gsa_pkg::ST_OK;
          res_slot   = hslot[SLOT_W-1:0];
          do_push    = (free_count < CNT_MAX);
          gen_we     = cmd.execute;
          gen_wa     = hslot[SLOT_W-1:0];
          gen_wd     = '0;
        end
      end
      default: begin
        res_status = gsa_pkg::ST_BAD;
      end
    endcase
  end

  assign stk_we = cmd.execute && do_push;

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_ctr     <= '0;
      free_count  <= '0;
      alloc_count <= '0;
    end else if (cmd.execute) begin
      if (do_acq) begin
        gen_ctr <= gen_inc;
      end
      if (do_pop) begin
        free_count <= free_dec;
      end else if (do_push) begin
        free_count <= free_count + CNT_W'(1);
      end
      if (do_new) begin
        alloc_count <= alloc_count + CNT_W'(1);
      end
    end
  end

  // Result register; the count shown is the one after this item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_slot   <= gsa_pkg::SLOTIDX_W'(res_slot);
      out_alloc  <= do_new ? gsa_pkg::ALLOC_W'(alloc_count + CNT_W'(1))
                           : gsa_pkg::ALLOC_W'(alloc_count);
    end
  end

  assign sts.out_blocked = out_valid && !out_ready;

endmodule

FILE: rtl/generational_slot_allocator_core.sv
// Generational slot allocator top level: acquire, lookup and retire handles.
// The accepting edge launches the registered reads of the generation memory and
// the free stack; the controller then moves to its execute state, which waits while
// a result is not taken, then writes back and loads the result register.
// The controller takes no new item until the current one is executed; a
// result not taken holds the next item back. Reset clears counters, not memories.
module generational_slot_allocator_core #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  gsa_req_if.sink     req,
  gsa_rsp_if.source   rsp
);

  gsa_pkg::gsa_cmd_t cmd;
  gsa_pkg::gsa_sts_t sts;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (req.op),
    .in_handle  (req.handle),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_handle (rsp.handle_out),
    .out_slot   (rsp.slot_index),
    .out_alloc  (rsp.allocated_slots)
  );

  // After an item is accepted, no further item is taken in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while another is being executed");

  // A failed operation returns neither a handle nor a slot.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != gsa_pkg::ST_OK) |->
      (rsp.handle_out == '0) && (rsp.slot_index == '0))
    else $error("failed operation returned a handle or slot");

  // Any handle issued carries a non-zero generation.
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == gsa_pkg::ST_OK) && (rsp.handle_out != '0) |->
      (rsp.handle_out[31:16] != '0))
    else $error("issued handle with generation zero");

endmodule
